### design/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// Holds the opcode codes, stream field widths and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int OPCODE_W = 2;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int TDATA_W  = 40;
    localparam int FLAGS_W  = 2;
    localparam int PAD_W    = TDATA_W - DATA_W - COUNT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } deq_cmd_t;

    typedef struct packed {
        logic out_free;
    } deq_status_t;

endpackage

`default_nettype wire

### design/deq_ctrl.sv
// Controller state machine of the double-ended queue core.
// Sequences capture, execution and result loading; depends on deq_pkg.
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  deq_status_t      status,
    output deq_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### design/deq_dpath.sv
// Datapath of the double-ended queue core: ring buffer memory, end indices,
// entry count and result register. Depends on deq_pkg.
`default_nettype none

module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  deq_cmd_t                cmd,
    output deq_status_t             status,
    input  wire logic [DATA_W-1:0]  s_tdata,
    input  wire logic [OPCODE_W-1:0] s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [FLAGS_W-1:0]      m_tuser
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    opcode_t                op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   pop_ok_reg;
    logic                   empty_err_reg;
    logic                   full_err_reg;
    logic [DATA_W-1:0]      out_value_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_empty_reg;
    logic                   out_full_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] back_reg;
    logic [IDX_W-1:0] back_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             is_push;
    logic             is_full;
    logic             is_empty;
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] back_inc;
    logic [IDX_W-1:0] back_dec;

    always_comb
    begin
        front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + IDX_W'(1);
        front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - IDX_W'(1);
        back_inc  = (back_reg == LAST_SLOT) ? '0 : back_reg + IDX_W'(1);
        back_dec  = (back_reg == '0) ? LAST_SLOT : back_reg - IDX_W'(1);
        is_push   = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT);
        is_full   = (count_reg == FULL_COUNT);
        is_empty  = (count_reg == '0);
        wr_en     = cmd.exec && is_push && !is_full;
        rd_en     = cmd.exec && !is_push && !is_empty;

        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        wr_addr    = back_reg;
        rd_addr    = front_reg;
        unique case (op_reg)
            OP_PUSH_BACK:
            begin
                wr_addr = back_reg;
                if (wr_en)
                begin
                    back_next  = back_inc;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                wr_addr = front_dec;
                if (wr_en)
                begin
                    front_next = front_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                rd_addr = front_reg;
                if (rd_en)
                begin
                    front_next = front_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                rd_addr = back_dec;
                if (rd_en)
                begin
                    back_next  = back_dec;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode_t'(s_tuser);
            val_reg <= VALUE_WIDTH'(s_tdata);
        end
        if (cmd.exec)
        begin
            pop_ok_reg    <= rd_en;
            empty_err_reg <= !is_push && is_empty;
            full_err_reg  <= is_push && is_full;
        end
        if (cmd.load)
        begin
            out_value_reg <= pop_ok_reg ? DATA_W'(rd_data_reg) : '0;
            out_count_reg <= COUNT_W'(count_reg);
            out_empty_reg <= empty_err_reg;
            out_full_reg  <= full_err_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {{PAD_W{1'b0}}, out_count_reg, out_value_reg};
    assign m_tuser         = {out_full_reg, out_empty_reg};

endmodule

`default_nettype wire

### design/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core on stream interfaces.
// Instantiates deq_ctrl and deq_dpath; depends on deq_pkg.
//
// Channel  Direction  tdata (lowest bit up)                    tuser (lowest bit up)
// s_*      in         push_value[31:0]                          opcode[1:0]
// m_*      out        pop_value[31:0], entry_count[36:32], pad  empty_error, full_error
//
// An input transaction is accepted in the capture cycle; the ring buffer access with the
// index update takes the next cycle and the result register is then loaded in the load step.
// The result is registered, and a new transaction is accepted only once the previous
// result has been loaded.
// A stalled result holds the controller in its load step until the result register frees.
// Reset clears the indices, the entry count and the controller; the memory is not cleared.
`default_nettype none

module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [DATA_W-1:0]   s_tdata,  // push_value
    input  wire logic [OPCODE_W-1:0] s_tuser,  // opcode
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata,  // pop_value, entry_count, zero pad
    output logic [FLAGS_W-1:0]       m_tuser   // empty_error, full_error
);

    deq_cmd_t    cmd;
    deq_status_t status;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### design/deq_checker.sv
// Port-level checker for the double-ended queue core, bound to the top level.
// Depends on deq_pkg for the stream widths.
`default_nettype none

module deq_checker
    import deq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [TDATA_W-1:0]  m_tdata,
    input wire logic [FLAGS_W-1:0]  m_tuser
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result changed or was withdrawn.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while a transaction was in progress.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("Empty and full errors reported together.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[DATA_W-1:0] == '0
            && m_tdata[DATA_W+COUNT_W-1:DATA_W] == '0)
        else $error("Empty error with a non-zero value or count.");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[DATA_W-1:0] == '0)
        else $error("Full error with a non-zero value.");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/double_ended_queue_core_tb.sv
// Self-checking testbench for double_ended_queue_core: directed corner cases, then random
// push and pop traffic with random idling on both stream channels.
// Depends on deq_pkg and the double_ended_queue_core RTL.
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [DATA_W-1:0]  pop_value;
        logic               empty_error;
        logic               full_error;
        logic [COUNT_W-1:0] entry_count;
    } deq_response_t;

    class deque_scoreboard;
        logic [DATA_W-1:0] slot_value [QUEUE_DEPTH];
        int unsigned       front_slot;
        int unsigned       back_slot;
        int unsigned       held;
        deq_response_t     expected_responses [$];
        int unsigned       mismatches;

        function new();
            front_slot = 0;
            back_slot  = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function void note_request(opcode_t op, logic [DATA_W-1:0] value);
            deq_response_t r;
            r = '0;
            if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.full_error = 1'b1;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    slot_value[back_slot] = value;
                    back_slot = (back_slot + 1) % QUEUE_DEPTH;
                    held++;
                end
                else
                begin
                    front_slot = (front_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    slot_value[front_slot] = value;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.empty_error = 1'b1;
                end
                else if (op == OP_POP_FRONT)
                begin
                    r.pop_value = slot_value[front_slot];
                    front_slot = (front_slot + 1) % QUEUE_DEPTH;
                    held--;
                end
                else
                begin
                    back_slot = (back_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    r.pop_value = slot_value[back_slot];
                    held--;
                end
            end
            r.entry_count = COUNT_W'(held);
            expected_responses.push_back(r);
        endfunction

        function void check_response(logic [TDATA_W-1:0] tdata, logic [FLAGS_W-1:0] tuser);
            deq_response_t want;
            deq_response_t got;
            got.pop_value   = tdata[DATA_W-1:0];
            got.entry_count = tdata[DATA_W +: COUNT_W];
            got.empty_error = tuser[0];
            got.full_error  = tuser[1];
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction: value %h empty %b full %b count %0d",
                             got.pop_value, got.empty_error, got.full_error, got.entry_count);
                return;
            end
            want = expected_responses.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: value %h/%h empty %b/%b full %b/%b count %0d/%0d (exp/act)",
                             want.pop_value, got.pop_value, want.empty_error, got.empty_error,
                             want.full_error, got.full_error, want.entry_count,
                             got.entry_count);
            end
        endfunction
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata  = '0;
    logic [OPCODE_W-1:0] s_tuser = OP_PUSH_BACK;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [FLAGS_W-1:0] m_tuser;

    logic            steady = 1'b0;
    int unsigned     quiet_cycles = 0;
    deque_scoreboard sb = new();

    double_ended_queue_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("double_ended_queue_core regression: fail");
            $finish;
        end
    end

    task automatic send_request(opcode_t op, logic [DATA_W-1:0] value);
        if (!steady)
        begin
            while ($urandom_range(99) < 35)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, value);
    endtask

    task automatic send_random_request(int unsigned push_pct);
        opcode_t op;
        if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        send_request(op, $urandom);
    endtask

    initial
    begin
        int unsigned phase_pct [6];
        int          i;

        phase_pct = '{85, 15, 50, 95, 5, 60};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on an empty queue, then the value extremes at both ends.
        send_request(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_request(OP_POP_BACK, 32'h0000_0000);
        send_request(OP_PUSH_BACK, 32'h0000_0000);
        send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(OP_POP_BACK, 32'h0000_0000);
        send_request(OP_POP_FRONT, 32'h0000_0000);

        // Fill from both ends so that the indices wrap, then push on a full queue.
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i % 2 == 0)
                send_request(OP_PUSH_BACK, 32'h1 << i);
            else
                send_request(OP_PUSH_FRONT, ~(32'h1 << i));
        end
        send_request(OP_PUSH_BACK, 32'hA5A5_A5A5);
        send_request(OP_PUSH_FRONT, 32'h5A5A_5A5A);
        send_request(OP_POP_FRONT, 32'h0000_0000);
        send_request(OP_POP_BACK, 32'hFFFF_FFFF);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady <= (i >= 180 && i < 280);
            send_random_request(phase_pct[(i / 40) % 6]);
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        while (sb.expected_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0)
            $display("double_ended_queue_core regression: pass");
        else
            $display("double_ended_queue_core regression: fail");
        $finish;
    end
endmodule

### double_ended_queue_core.f
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue_core.sv
design/deq_checker.sv
tb/double_ended_queue_core_tb.sv
